[hdl/pkc_pkg.sv]
package pkc_pkg;

    // Byte count of the longest keyword, and how many keywords there are.
    localparam int KW_MAX_LEN = 9;
    localparam int KW_COUNT   = 21;
    localparam int HIT_BITS   = 9;
    localparam int WIN_DEPTH  = 8;
    localparam int PREFIX_LEN = 10;

    typedef logic [7:0] byte_t;
    typedef logic [HIT_BITS-1:0] hit_vec_t;
    // Element 0 is the newest byte.
    typedef logic [WIN_DEPTH-1:0][7:0] window_t;
    // Element 0 is the last character of the keyword.
    typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;
    typedef logic [PREFIX_LEN-1:0][7:0] prefix_text_t;

    typedef enum logic [2:0] {
        CAT_UNKNOWN     = 3'd0,
        CAT_DATA        = 3'd1,
        CAT_METADATA    = 3'd2,
        CAT_CONSISTENCY = 3'd3,
        CAT_RELIABILITY = 3'd4,
        CAT_FILESYSTEM  = 3'd5,
        CAT_TEMPORARY   = 3'd6,
        CAT_ADMIN       = 3'd7
    } category_t;

    // Hit flag positions.
    localparam int HIT_SYS   = 0;
    localparam int HIT_XL    = 1;
    localparam int HIT_CONS  = 2;
    localparam int HIT_FS    = 3;
    localparam int HIT_ADMIN = 4;
    localparam int HIT_REL   = 5;
    localparam int HIT_DATA  = 6;
    localparam int HIT_TEMP  = 7;
    localparam int HIT_SLASH = 8;

    localparam byte_t CHR_SLASH = 8'h2f;
    localparam byte_t CHR_DOT   = 8'h2e;
    localparam byte_t CHR_NUL   = 8'h00;

    // Object-store system directory prefix, first character in the highest element.
    localparam prefix_text_t SYS_PREFIX = 80'h2e6d696e696f2e737973;

    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        "xl.meta",
        "wal", "WAL", "raft", "trans",
        "jour", "jbd",
        "conf", ".log", "acces", "error",
        "heal", "replic",
        "data", "object", "bucket", 40'h6d696e696f,
        ".tmp", ".part", "multipart", "/tmp/"
    };

    localparam int KW_LEN [KW_COUNT] = '{
        7,
        3, 3, 4, 5,
        4, 3,
        4, 4, 5, 5,
        4, 6,
        4, 6, 6, 5,
        4, 5, 9, 5
    };

    localparam hit_vec_t KW_MASK [KW_COUNT] = '{
        hit_vec_t'(1) << HIT_XL,
        hit_vec_t'(1) << HIT_CONS, hit_vec_t'(1) << HIT_CONS,
        hit_vec_t'(1) << HIT_CONS, hit_vec_t'(1) << HIT_CONS,
        hit_vec_t'(1) << HIT_FS, hit_vec_t'(1) << HIT_FS,
        hit_vec_t'(1) << HIT_ADMIN, hit_vec_t'(1) << HIT_ADMIN,
        hit_vec_t'(1) << HIT_ADMIN, hit_vec_t'(1) << HIT_ADMIN,
        hit_vec_t'(1) << HIT_REL, hit_vec_t'(1) << HIT_REL,
        hit_vec_t'(1) << HIT_DATA, hit_vec_t'(1) << HIT_DATA,
        hit_vec_t'(1) << HIT_DATA, hit_vec_t'(1) << HIT_DATA,
        hit_vec_t'(1) << HIT_TEMP, hit_vec_t'(1) << HIT_TEMP,
        hit_vec_t'(1) << HIT_TEMP, hit_vec_t'(1) << HIT_TEMP
    };

    // One accepted byte on its way into the scanner.
    typedef struct packed {
        logic  valid;
        logic  last;
        byte_t path_byte;
    } scan_step_t;

    // Fixed priority from the hit flags to a category.
    function automatic category_t resolve_category(hit_vec_t hits);
        category_t cat;
        priority if (hits[HIT_SYS] || hits[HIT_XL]) cat = CAT_METADATA;
        else if (hits[HIT_CONS])                    cat = CAT_CONSISTENCY;
        else if (hits[HIT_FS])                      cat = CAT_FILESYSTEM;
        else if (hits[HIT_ADMIN])                   cat = CAT_ADMIN;
        else if (hits[HIT_REL])                     cat = CAT_RELIABILITY;
        else if (hits[HIT_DATA])                    cat = CAT_DATA;
        else if (hits[HIT_TEMP])                    cat = CAT_TEMPORARY;
        else if (hits[HIT_SLASH])                   cat = CAT_DATA;
        else                                        cat = CAT_UNKNOWN;
        return cat;
    endfunction

endpackage

[hdl/pkc_match.sv]
module pkc_match
    import pkc_pkg::*;
#(
    parameter int START_LIMIT = 60,
    parameter int PW          = 6
) (
    input  byte_t        cur,
    input  window_t      window,
    input  logic [PW-1:0] pos,
    input  logic         prefix_alive,
    output hit_vec_t     found,
    output logic         prefix_alive_next
);

    always_comb begin
        logic kw_ok;
        found             = '0;
        prefix_alive_next = prefix_alive;

        // Every keyword that ends on the current byte is checked at once.
        for (int k = 0; k < KW_COUNT; k++) begin
            kw_ok = (int'(pos) >= KW_LEN[k] - 1) &&
                    (int'(pos) < START_LIMIT + KW_LEN[k] - 1) &&
                    (cur == KW_TEXT[k][0]);
            for (int j = 1; j < KW_MAX_LEN; j++) begin
                if (j < KW_LEN[k] && window[j-1] != KW_TEXT[k][j]) begin
                    kw_ok = 1'b0;
                end
            end
            if (kw_ok) begin
                found = found | KW_MASK[k];
            end
        end

        if (pos >= PW'(1) && int'(pos) < START_LIMIT + 1 && window[0] == CHR_SLASH &&
            cur != CHR_DOT && cur != CHR_NUL) begin
            found[HIT_SLASH] = 1'b1;
        end

        if (pos < PW'(PREFIX_LEN)) begin
            prefix_alive_next = prefix_alive &&
                                (cur == SYS_PREFIX[4'(PREFIX_LEN - 1) - pos[3:0]]);
            if (pos == PW'(PREFIX_LEN - 1) && prefix_alive_next) begin
                found[HIT_SYS] = 1'b1;
            end
        end
    end

endmodule

[hdl/pkc_scan.sv]
module pkc_scan
    import pkc_pkg::*;
#(
    parameter int PATH_BYTES  = 64,
    parameter int START_LIMIT = 60
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  scan_step_t step,
    output hit_vec_t   hits_next
);

    localparam int PW = $clog2(PATH_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(PATH_BYTES - 1);

    logic [PW-1:0] pos_reg;
    window_t       window_reg;
    logic          prefix_alive_reg;
    logic          ended_reg;
    hit_vec_t      hits_reg;

    byte_t    cur;
    hit_vec_t found;
    logic     prefix_alive_next;

    // Past the terminator or the end of the buffer every byte reads as zero.
    assign cur       = (ended_reg || pos_reg >= POS_LAST) ? CHR_NUL : step.path_byte;
    assign hits_next = hits_reg | found;

    pkc_match #(
        .START_LIMIT (START_LIMIT),
        .PW          (PW)
    ) u_match (
        .cur               (cur),
        .window            (window_reg),
        .pos               (pos_reg),
        .prefix_alive      (prefix_alive_reg),
        .found             (found),
        .prefix_alive_next (prefix_alive_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            window_reg       <= '0;
            prefix_alive_reg <= 1'b1;
            ended_reg        <= 1'b0;
            hits_reg         <= '0;
        end else if (step.valid) begin
            if (step.last) begin
                pos_reg          <= '0;
                window_reg       <= '0;
                prefix_alive_reg <= 1'b1;
                ended_reg        <= 1'b0;
                hits_reg         <= '0;
            end else begin
                if (pos_reg < POS_LAST) begin
                    pos_reg <= pos_reg + PW'(1);
                end
                window_reg       <= {window_reg[WIN_DEPTH-2:0], cur};
                prefix_alive_reg <= prefix_alive_next;
                ended_reg        <= ended_reg || (cur == CHR_NUL);
                hits_reg         <= hits_next;
            end
        end
    end

endmodule

[hdl/path_keyword_classifier_top.sv]
// Path keyword classifier.
//
// The slave channel takes a file path one byte per transaction: s_tdata[7:0]
// carries the character and s_tlast marks the final byte of the path. The
// first zero byte ends the string; bytes after it, and bytes at buffer position
// PATH_BYTES-1 and later, count as zero. A keyword counts only when it starts
// before position START_LIMIT.
// When the byte marked last has been processed, one transaction appears on the
// master channel with the category in m_tdata[2:0]. Bytes without tlast give
// no result.
// Throughput is one byte per cycle while no last byte waits for the output
// register. The byte goes into an input register, all keyword windows are
// compared against it in parallel as it leaves that register, and for a last
// byte the category then lands in the output register, which drives m_tvalid.
// When the master side stalls, the output register holds the category and the
// next path keeps streaming into the scanner; only a further last byte waits
// for the output register to free up, which then backs up s_tready.
// Reset (aresetn low, synchronous) empties both registers and clears the scan
// state; the scan state is also cleared after every last byte.
module path_keyword_classifier_top
    import pkc_pkg::*;
#(
    parameter int PATH_BYTES  = 64,
    parameter int START_LIMIT = 60
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] path_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [2:0] category, [7:3] zero
);

    logic      in_valid_reg;
    logic      in_last_reg;
    byte_t     in_byte_reg;
    logic      out_valid_reg;
    category_t out_cat_reg;

    logic       out_free;
    logic       core_fire;
    scan_step_t step;
    hit_vec_t   hits_next;

    // A byte without tlast never needs the output register; a last byte
    // needs it empty or being emptied in this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    assign core_fire = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || core_fire;

    assign step.valid     = core_fire;
    assign step.last      = in_last_reg;
    assign step.path_byte = in_byte_reg;

    pkc_scan #(
        .PATH_BYTES  (PATH_BYTES),
        .START_LIMIT (START_LIMIT)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .hits_next (hits_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && in_last_reg) begin
            out_cat_reg <= resolve_category(hits_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_cat_reg};

endmodule
